// ----- rtl/wsd_pkg.sv -----
`default_nettype none

package wsd_pkg;

    localparam int CAPACITY_BITS = 20;
    localparam int CAP_W         = CAPACITY_BITS + 1;
    localparam int OFFSET_W      = CAPACITY_BITS;
    localparam int REM_W         = 64;

    localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(1) << CAPACITY_BITS;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [3:0] LEN_BYTES_16 = 4'd2;
    localparam logic [3:0] LEN_BYTES_64 = 4'd8;
    localparam logic [3:0] MASK_BYTES   = 4'd4;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT,
        PH_MASK,
        PH_DATA,
        PH_CLOSED
    } t_phase;

    typedef struct packed {
        logic                payload_valid;
        logic [7:0]          payload_byte;
        logic [OFFSET_W-1:0] payload_offset;
        logic                message_done;
        logic [CAP_W-1:0]    message_length;
        logic                connection_closed;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/websocket_frame_deframer.sv -----
// WebSocket receive deframer.
// Input channel: one received byte per beat (i_valid / o_ready, i_rx_byte).
// Output channel: one result beat (o_valid / i_ready) per kept payload byte,
// per completed message, or per close; a payload byte and a message completion
// that fall on the same input byte share one beat.
// Config channel: i_cfg_valid / o_cfg_ready carries buffer_capacity; it is
// always ready and must only be written while no bytes are in flight.
// The accepting edge loads the input register; the result register takes the
// parser's result when the output is free.
// Throughput: one byte per cycle while the receiver does not stall; each byte
// is a single small state update in the parser between the input register and
// the result register.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more byte; further input is then held off.
// Bytes that produce no result (headers, dropped frames) pass without
// occupying the output.
// Reset (synchronous, active low) returns to expecting a frame header, clears
// the message fill and the closed condition, and sets the capacity to 2^20.
// After a close frame all further bytes are accepted and ignored until reset.
`default_nettype none

module websocket_frame_deframer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [7:0]                        i_rx_byte,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [wsd_pkg::CAP_W-1:0]         i_cfg_buffer_capacity,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic                                   o_payload_valid,
    output logic [7:0]                             o_payload_byte,
    output logic [wsd_pkg::OFFSET_W-1:0]           o_payload_offset,
    output logic                                   o_message_done,
    output logic [wsd_pkg::CAP_W-1:0]              o_message_length,
    output logic                                   o_connection_closed
);

    logic                        r_in_valid;
    logic [7:0]                  r_in_byte;
    logic [wsd_pkg::CAP_W-1:0]   r_capacity;
    logic                        r_out_valid;
    wsd_pkg::t_result            r_out;
    wsd_pkg::t_result            step_result;
    logic                        step_emit;
    logic                        out_free;
    logic                        consume;

    assign out_free    = !r_out_valid || i_ready;
    assign consume     = r_in_valid && out_free;
    assign o_ready     = !r_in_valid || consume;
    assign o_cfg_ready = 1'b1;

    wsd_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (consume),
        .i_byte     (r_in_byte),
        .i_capacity (r_capacity),
        .o_result   (step_result),
        .o_emit     (step_emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_capacity  <= wsd_pkg::CAP_MAX;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= consume && step_emit;
            end
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_buffer_capacity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (out_free) begin
            r_out <= step_result;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_payload_valid     = r_out.payload_valid;
    assign o_payload_byte      = r_out.payload_byte;
    assign o_payload_offset    = r_out.payload_offset;
    assign o_message_done      = r_out.message_done;
    assign o_message_length    = r_out.message_length;
    assign o_connection_closed = r_out.connection_closed;

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready |=> r_out_valid && $stable(r_out))
        else $error("result beat lost under stall");

    a_no_take_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_ready |-> !o_ready)
        else $error("input accepted with both stages full");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.payload_valid || r_out.message_done
                        || r_out.connection_closed)
        else $error("result beat with nothing in it");

endmodule

`default_nettype wire

// ----- rtl/wsd_parser.sv -----
`default_nettype none

module wsd_parser (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic [7:0]                    i_byte,
    input  wire logic [wsd_pkg::CAP_W-1:0]     i_capacity,
    output wsd_pkg::t_result                   o_result,
    output logic                               o_emit
);

    wsd_pkg::t_phase r_phase, n_phase, hc_target;

    logic                        r_final, n_final;
    logic [3:0]                  r_opcode, n_opcode;
    logic                        r_masked, n_masked;
    logic [3:0]                  r_left, n_left;
    logic [wsd_pkg::REM_W-1:0]   r_rem, n_rem;
    logic [31:0]                 r_key, n_key;
    logic [1:0]                  r_pos, n_pos;
    logic                        r_keep, n_keep;
    logic [wsd_pkg::CAP_W-1:0]   r_fill, n_fill;

    logic [6:0]                  len7;
    logic                        ext_len;
    logic [wsd_pkg::REM_W-1:0]   rem_next;
    logic                        rem_next_zero;
    logic                        hc;
    logic                        is_close;
    logic                        data_op;
    logic [wsd_pkg::CAP_W-1:0]   cap_eff;
    logic [wsd_pkg::CAP_W-1:0]   room;
    logic                        fits;
    logic                        keep_new;
    logic [wsd_pkg::CAP_W-1:0]   fill_hdr;
    logic [wsd_pkg::CAP_W-1:0]   fill_inc;
    logic                        data_last;
    logic [7:0]                  key_byte;

    assign len7      = i_byte[6:0];
    assign ext_len   = (len7 == wsd_pkg::LEN_EXT16) || (len7 == wsd_pkg::LEN_EXT64);
    assign is_close  = (r_opcode == wsd_pkg::OP_CLOSE);
    assign data_op   = (r_opcode == wsd_pkg::OP_CONT) || (r_opcode == wsd_pkg::OP_TEXT);
    assign cap_eff   = (i_capacity > wsd_pkg::CAP_MAX) ? wsd_pkg::CAP_MAX : i_capacity;
    assign room      = cap_eff - r_fill;
    assign fits      = (r_fill <= cap_eff)
                     && (rem_next[wsd_pkg::REM_W-1:wsd_pkg::CAP_W] == '0)
                     && (rem_next[wsd_pkg::CAP_W-1:0] <= room);
    assign keep_new  = data_op && fits;
    assign fill_hdr  = keep_new ? r_fill : '0;
    assign rem_next_zero = (rem_next == '0);
    assign fill_inc  = r_fill + wsd_pkg::CAP_W'(1);
    assign data_last = (r_rem == wsd_pkg::REM_W'(1));
    assign key_byte  = r_key[{~r_pos, 3'b000} +: 8];
    assign hc_target = is_close ? wsd_pkg::PH_CLOSED
                     : (rem_next_zero ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_DATA);

    always_comb begin
        rem_next = r_rem;
        hc       = 1'b0;
        unique case (r_phase)
            wsd_pkg::PH_HDR1: begin
                rem_next = ext_len ? '0 : wsd_pkg::REM_W'(len7);
                hc       = !ext_len && !i_byte[7];
            end
            wsd_pkg::PH_EXT: begin
                rem_next = {r_rem[wsd_pkg::REM_W-9:0], i_byte};
                hc       = (r_left == 4'd1) && !r_masked;
            end
            wsd_pkg::PH_MASK: begin
                hc       = (r_left == 4'd1);
            end
            wsd_pkg::PH_DATA: begin
                rem_next = r_rem - wsd_pkg::REM_W'(1);
            end
            default: begin
                rem_next = r_rem;
            end
        endcase
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        if (i_step) begin
            unique case (r_phase)
                wsd_pkg::PH_HDR0: n_phase = wsd_pkg::PH_HDR1;
                wsd_pkg::PH_HDR1: begin
                    if (ext_len)        n_phase = wsd_pkg::PH_EXT;
                    else if (i_byte[7]) n_phase = wsd_pkg::PH_MASK;
                    else                n_phase = hc_target;
                end
                wsd_pkg::PH_EXT: begin
                    if (r_left == 4'd1) n_phase = r_masked ? wsd_pkg::PH_MASK : hc_target;
                end
                wsd_pkg::PH_MASK: begin
                    if (r_left == 4'd1) n_phase = hc_target;
                end
                wsd_pkg::PH_DATA: begin
                    if (data_last) n_phase = wsd_pkg::PH_HDR0;
                end
                wsd_pkg::PH_CLOSED: n_phase = wsd_pkg::PH_CLOSED;
                default:            n_phase = wsd_pkg::PH_HDR0;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        n_final  = r_final;
        n_opcode = r_opcode;
        n_masked = r_masked;
        n_left   = r_left;
        n_rem    = r_rem;
        n_key    = r_key;
        n_pos    = r_pos;
        n_keep   = r_keep;
        n_fill   = r_fill;
        o_result = '0;
        o_emit   = 1'b0;
        if (i_step) begin
            unique case (r_phase)
                wsd_pkg::PH_HDR0: begin
                    n_final  = i_byte[7];
                    n_opcode = i_byte[3:0];
                end
                wsd_pkg::PH_HDR1: begin
                    n_masked = i_byte[7];
                    n_key    = '0;
                    n_pos    = '0;
                    n_rem    = rem_next;
                    if (ext_len) begin
                        n_left = (len7 == wsd_pkg::LEN_EXT16) ? wsd_pkg::LEN_BYTES_16
                                                              : wsd_pkg::LEN_BYTES_64;
                    end else if (i_byte[7]) begin
                        n_left = wsd_pkg::MASK_BYTES;
                    end
                end
                wsd_pkg::PH_EXT: begin
                    n_rem  = rem_next;
                    n_left = r_left - 4'd1;
                    if (r_left == 4'd1 && r_masked) begin
                        n_left = wsd_pkg::MASK_BYTES;
                    end
                end
                wsd_pkg::PH_MASK: begin
                    n_key  = {r_key[23:0], i_byte};
                    n_left = r_left - 4'd1;
                end
                wsd_pkg::PH_DATA: begin
                    n_rem = rem_next;
                    n_pos = r_pos + 2'd1;
                    if (r_keep) begin
                        o_result.payload_valid  = 1'b1;
                        o_result.payload_byte   = i_byte ^ key_byte;
                        o_result.payload_offset = r_fill[wsd_pkg::OFFSET_W-1:0];
                        n_fill                  = fill_inc;
                        o_emit                  = 1'b1;
                    end
                    if (data_last && r_final) begin
                        o_result.message_done   = 1'b1;
                        o_result.message_length = r_keep ? fill_inc : r_fill;
                        n_fill                  = '0;
                        o_emit                  = 1'b1;
                    end
                end
                default: begin
                    n_fill = r_fill;
                end
            endcase

            // header complete
            if (hc) begin
                if (is_close) begin
                    o_result.connection_closed = 1'b1;
                    o_emit                     = 1'b1;
                end else begin
                    n_keep = keep_new;
                    n_fill = fill_hdr;
                    n_pos  = '0;
                    if (rem_next_zero && r_final) begin
                        o_result.message_done   = 1'b1;
                        o_result.message_length = fill_hdr;
                        n_fill                  = '0;
                        o_emit                  = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= wsd_pkg::PH_HDR0;
            r_final  <= 1'b0;
            r_opcode <= '0;
            r_masked <= 1'b0;
            r_left   <= '0;
            r_rem    <= '0;
            r_key    <= '0;
            r_pos    <= '0;
            r_keep   <= 1'b0;
            r_fill   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_final  <= n_final;
            r_opcode <= n_opcode;
            r_masked <= n_masked;
            r_left   <= n_left;
            r_rem    <= n_rem;
            r_key    <= n_key;
            r_pos    <= n_pos;
            r_keep   <= n_keep;
            r_fill   <= n_fill;
        end
    end

    a_closed_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == wsd_pkg::PH_CLOSED |-> !o_emit)
        else $error("result produced after close");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= wsd_pkg::CAP_MAX)
        else $error("message fill beyond capacity");

    a_payload_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.payload_valid |-> (r_phase == wsd_pkg::PH_DATA) && r_keep)
        else $error("payload byte outside a kept frame");

    a_close_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.connection_closed |=> r_phase == wsd_pkg::PH_CLOSED)
        else $error("close reported without entering closed phase");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam logic [3:0] OP_RSVD = 4'h3;
    localparam logic [3:0] OP_PING = 4'h9;
    localparam logic [3:0] OP_PONG = 4'hA;

    localparam int LEN_AUTO    = 0;
    localparam int LEN_FORCE16 = 1;
    localparam int LEN_FORCE64 = 2;

    localparam int BYTE_TARGET = 650;
    localparam int CFG_EVERY   = 150;
    localparam int LIMIT       = 400000;

    class deframe_scoreboard;
        logic [wsd_pkg::CAP_W-1:0] capacity;
        wsd_pkg::t_phase           phase;
        bit                        fin;
        logic [3:0]                opcode;
        bit                        masked;
        logic [3:0]                len_left;
        logic [63:0]               remaining;
        logic [31:0]               key;
        logic [1:0]                key_pos;
        bit                        keep;
        logic [63:0]               fill;
        wsd_pkg::t_result          due_beats[$];
        int                        errors;

        function new();
            capacity  = wsd_pkg::CAP_MAX;
            phase     = wsd_pkg::PH_HDR0;
            fin       = 0;
            opcode    = '0;
            masked    = 0;
            len_left  = '0;
            remaining = '0;
            key       = '0;
            key_pos   = '0;
            keep      = 0;
            fill      = '0;
            errors    = 0;
        endfunction

        function void set_capacity(logic [wsd_pkg::CAP_W-1:0] v);
            capacity = v;
        endfunction

        function void close_message(inout wsd_pkg::t_result r);
            r.message_done   = 1'b1;
            r.message_length = fill[wsd_pkg::CAP_W-1:0];
            fill = '0;
        endfunction

        function bit finish_header(inout wsd_pkg::t_result r);
            logic [63:0] cap;
            cap = (capacity > wsd_pkg::CAP_MAX) ? 64'(wsd_pkg::CAP_MAX) : 64'(capacity);
            if (opcode == wsd_pkg::OP_CLOSE) begin
                phase = wsd_pkg::PH_CLOSED;
                r.connection_closed = 1'b1;
                return 1;
            end
            keep = (opcode == wsd_pkg::OP_CONT || opcode == wsd_pkg::OP_TEXT) &&
                   fill <= cap && remaining <= cap - fill;
            if (!keep)
                fill = '0;
            key_pos = '0;
            if (remaining == 0) begin
                phase = wsd_pkg::PH_HDR0;
                if (fin) begin
                    close_message(r);
                    return 1;
                end
                return 0;
            end
            phase = wsd_pkg::PH_DATA;
            return 0;
        endfunction

        function void note_byte(logic [7:0] b);
            wsd_pkg::t_result r;
            bit               hit;
            logic [6:0]       n;
            logic [7:0]       kb;
            int               sh;
            r   = '0;
            hit = 0;
            case (phase)
                wsd_pkg::PH_HDR0: begin
                    fin    = b[7];
                    opcode = b[3:0];
                    phase  = wsd_pkg::PH_HDR1;
                end
                wsd_pkg::PH_HDR1: begin
                    n         = b[6:0];
                    masked    = b[7];
                    key       = '0;
                    key_pos   = '0;
                    remaining = '0;
                    if (n == wsd_pkg::LEN_EXT16 || n == wsd_pkg::LEN_EXT64) begin
                        len_left = (n == wsd_pkg::LEN_EXT16) ? wsd_pkg::LEN_BYTES_16
                                                             : wsd_pkg::LEN_BYTES_64;
                        phase    = wsd_pkg::PH_EXT;
                    end else begin
                        remaining = 64'(n);
                        if (masked) begin
                            len_left = wsd_pkg::MASK_BYTES;
                            phase    = wsd_pkg::PH_MASK;
                        end else begin
                            hit = finish_header(r);
                        end
                    end
                end
                wsd_pkg::PH_EXT: begin
                    remaining = {remaining[55:0], b};
                    len_left  = len_left - 4'd1;
                    if (len_left == 0) begin
                        if (masked) begin
                            len_left = wsd_pkg::MASK_BYTES;
                            phase    = wsd_pkg::PH_MASK;
                        end else begin
                            hit = finish_header(r);
                        end
                    end
                end
                wsd_pkg::PH_MASK: begin
                    key      = {key[23:0], b};
                    len_left = len_left - 4'd1;
                    if (len_left == 0)
                        hit = finish_header(r);
                end
                wsd_pkg::PH_DATA: begin
                    sh = 24 - 8 * int'(key_pos);
                    kb = 8'(key >> sh);
                    if (keep) begin
                        r.payload_valid  = 1'b1;
                        r.payload_byte   = b ^ kb;
                        r.payload_offset = fill[wsd_pkg::OFFSET_W-1:0];
                        fill = fill + 64'd1;
                        hit  = 1;
                    end
                    key_pos   = key_pos + 2'd1;
                    remaining = remaining - 64'd1;
                    if (remaining == 0) begin
                        phase = wsd_pkg::PH_HDR0;
                        if (fin) begin
                            close_message(r);
                            hit = 1;
                        end
                    end
                end
                default: ;
            endcase
            if (hit)
                due_beats.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_beat(wsd_pkg::t_result got);
            wsd_pkg::t_result want;
            if (due_beats.size() == 0) begin
                $error("result beat with nothing expected: %p", got);
                errors++;
                return;
            end
            want = due_beats.pop_front();
            compare_field("payload_valid", 64'(want.payload_valid), 64'(got.payload_valid));
            compare_field("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
            compare_field("payload_offset", 64'(want.payload_offset), 64'(got.payload_offset));
            compare_field("message_done", 64'(want.message_done), 64'(got.message_done));
            compare_field("message_length", 64'(want.message_length),
                          64'(got.message_length));
            compare_field("connection_closed", 64'(want.connection_closed),
                          64'(got.connection_closed));
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic [7:0]                   i_rx_byte;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [wsd_pkg::CAP_W-1:0]    i_cfg_buffer_capacity;
    logic                         o_valid;
    logic                         i_ready;
    logic                         o_payload_valid;
    logic [7:0]                   o_payload_byte;
    logic [wsd_pkg::OFFSET_W-1:0] o_payload_offset;
    logic                         o_message_done;
    logic [wsd_pkg::CAP_W-1:0]    o_message_length;
    logic                         o_connection_closed;

    deframe_scoreboard         sb;
    int                        sent_bytes;
    int                        cycles;
    int                        tx_quiet;
    int                        rx_quiet;
    logic [wsd_pkg::CAP_W-1:0] cur_cap;

    websocket_frame_deframer u_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_rx_byte             (i_rx_byte),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_buffer_capacity (i_cfg_buffer_capacity),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_payload_valid       (o_payload_valid),
        .o_payload_byte        (o_payload_byte),
        .o_payload_offset      (o_payload_offset),
        .o_message_done        (o_message_done),
        .o_message_length      (o_message_length),
        .o_connection_closed   (o_connection_closed)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("** websocket_frame_deframer: FAILED **");
        $finish;
    end

    // random gaps, with occasional back-to-back stretches
    function automatic int pick_gap(ref int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            quiet_left = $urandom_range(10, 40);
        return $urandom_range(0, 7);
    endfunction

    function automatic int unsigned pick_len();
        case ($urandom_range(0, 9))
            0: return $urandom_range(126, 260);
            1: return (cur_cap <= 64) ? int'(cur_cap) : $urandom_range(0, 3);
            2: return 0;
            default: return $urandom_range(1, 24);
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        sb.note_byte(b);
        sent_bytes++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (sb.due_beats.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [wsd_pkg::CAP_W-1:0] v);
        settle();
        i_cfg_valid           <= 1'b1;
        i_cfg_buffer_capacity <= v;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        sb.set_capacity(v);
        cur_cap = v;
    endtask

    task automatic send_frame(input bit fin, input logic [3:0] op, input int unsigned len,
                              input bit masked, input int form, input logic [2:0] rsv);
        logic [31:0] key;
        logic [63:0] len64;
        key   = $urandom();
        len64 = 64'(len);
        push_byte({fin, rsv, op});
        if (form == LEN_AUTO && len < 126) begin
            push_byte({masked, 7'(len)});
        end else if (form != LEN_FORCE64 && len < 65536) begin
            push_byte({masked, wsd_pkg::LEN_EXT16});
            push_byte(len64[15:8]);
            push_byte(len64[7:0]);
        end else begin
            push_byte({masked, wsd_pkg::LEN_EXT64});
            for (int i = 7; i >= 0; i--)
                push_byte(len64[8*i +: 8]);
        end
        if (masked)
            for (int i = 3; i >= 0; i--)
                push_byte(key[8*i +: 8]);
        repeat (len) push_byte(8'($urandom()));
    endtask

    // receive side
    initial begin
        int               stall;
        wsd_pkg::t_result got;
        i_ready <= 1'b0;
        rx_quiet = 0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = pick_gap(rx_quiet);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            got = {o_payload_valid, o_payload_byte, o_payload_offset,
                   o_message_done, o_message_length, o_connection_closed};
            sb.check_beat(got);
        end
    end

    initial begin
        int                        frags;
        int                        next_cfg;
        int                        form;
        bit                        msk;
        logic [3:0]                op;
        logic [2:0]                rsv;
        logic [31:0]               key;
        logic [wsd_pkg::CAP_W-1:0] cap_pick [8];

        sb = new();
        sent_bytes = 0;
        tx_quiet   = 0;
        cur_cap    = wsd_pkg::CAP_MAX;
        cap_pick   = '{21'd0, 21'd1, 21'd8, 21'd20, 21'd48, 21'd300, wsd_pkg::CAP_MAX,
                       21'h1FFFFF};

        i_rst_n               <= 1'b0;
        i_valid               <= 1'b0;
        i_rx_byte             <= '0;
        i_cfg_valid           <= 1'b0;
        i_cfg_buffer_capacity <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames
        write_capacity(wsd_pkg::CAP_MAX);
        send_frame(1, wsd_pkg::OP_TEXT, 0, 0, LEN_AUTO, 3'd0);
        send_frame(1, wsd_pkg::OP_TEXT, 3, 1, LEN_AUTO, 3'd0);
        push_byte({1'b1, 3'd0, wsd_pkg::OP_TEXT});
        push_byte(8'd2);
        push_byte(8'h00);
        push_byte(8'hFF);
        send_frame(0, wsd_pkg::OP_TEXT, 2, 1, LEN_AUTO, 3'd0);
        send_frame(1, OP_PING, 1, 1, LEN_AUTO, 3'd0);
        send_frame(1, wsd_pkg::OP_CONT, 2, 0, LEN_AUTO, 3'd0);
        send_frame(0, wsd_pkg::OP_TEXT, 0, 1, LEN_AUTO, 3'd0);
        send_frame(1, wsd_pkg::OP_CONT, 0, 0, LEN_AUTO, 3'd0);
        send_frame(1, wsd_pkg::OP_TEXT, 5, 1, LEN_FORCE16, 3'd0);
        send_frame(1, wsd_pkg::OP_TEXT, 3, 0, LEN_FORCE64, 3'd0);
        send_frame(1, wsd_pkg::OP_TEXT, 2, 1, LEN_AUTO, 3'b111);
        send_frame(1, OP_RSVD, 2, 0, LEN_AUTO, 3'd0);
        send_frame(1, wsd_pkg::OP_TEXT, 126, 0, LEN_AUTO, 3'd0);
        // capacity lowered below the fill of an open message
        send_frame(0, wsd_pkg::OP_TEXT, 6, 0, LEN_AUTO, 3'd0);
        write_capacity(21'd4);
        send_frame(1, wsd_pkg::OP_CONT, 0, 0, LEN_AUTO, 3'd0);
        send_frame(1, wsd_pkg::OP_TEXT, 4, 1, LEN_AUTO, 3'd0);
        send_frame(1, wsd_pkg::OP_TEXT, 5, 1, LEN_AUTO, 3'd0);
        write_capacity(21'd0);
        send_frame(1, wsd_pkg::OP_TEXT, 0, 0, LEN_AUTO, 3'd0);
        send_frame(1, wsd_pkg::OP_TEXT, 1, 0, LEN_AUTO, 3'd0);
        write_capacity(21'h1FFFFF);
        send_frame(1, wsd_pkg::OP_TEXT, 3, 1, LEN_AUTO, 3'd0);

        // random messages with control frames and stray fragments mixed in
        next_cfg = sent_bytes;
        while (sent_bytes < BYTE_TARGET) begin
            if (sent_bytes >= next_cfg) begin
                if ($urandom_range(0, 3) == 0)
                    write_capacity(wsd_pkg::CAP_W'($urandom()));
                else
                    write_capacity(cap_pick[$urandom_range(0, 7)]);
                next_cfg = sent_bytes + CFG_EVERY;
            end
            frags = $urandom_range(1, 3);
            for (int f = 0; f < frags; f++) begin
                if ($urandom_range(0, 5) == 0) begin
                    op = 4'($urandom());
                    if (op == wsd_pkg::OP_CLOSE)
                        op = OP_PONG;
                    send_frame(1'($urandom()), op, $urandom_range(0, 8), 1'($urandom()),
                               LEN_AUTO, 3'($urandom()));
                end
                case ($urandom_range(0, 9))
                    0: form = LEN_FORCE16;
                    1: form = LEN_FORCE64;
                    default: form = LEN_AUTO;
                endcase
                msk = 1'($urandom());
                rsv = ($urandom_range(0, 7) == 0) ? 3'($urandom()) : 3'd0;
                op  = (f == 0 && $urandom_range(0, 7) != 0) ? wsd_pkg::OP_TEXT
                                                             : wsd_pkg::OP_CONT;
                send_frame(f == frags - 1, op, pick_len(), msk, form, rsv);
            end
        end

        // close with an all-ones 64-bit length, then bytes that must be ignored
        key = $urandom();
        push_byte({1'b1, 3'd0, wsd_pkg::OP_CLOSE});
        push_byte({1'b1, wsd_pkg::LEN_EXT64});
        repeat (8) push_byte(8'hFF);
        for (int i = 3; i >= 0; i--)
            push_byte(key[8*i +: 8]);
        push_byte({1'b1, 3'd0, wsd_pkg::OP_TEXT});
        push_byte(8'd0);
        repeat (3) push_byte(8'($urandom()));
        i_valid <= 1'b0;
        while (sb.due_beats.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (sb.errors == 0)
            $display("** websocket_frame_deframer: PASSED **");
        else
            $display("** websocket_frame_deframer: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/wsd_pkg.sv
rtl/wsd_parser.sv
rtl/websocket_frame_deframer.sv
tb/testbench.sv
